/* sv/mdss_pkg.sv */
`default_nettype none

package mdss_pkg;

  localparam int unsigned SHIFT_BITS_DEF = 16;
  localparam int unsigned DIGIT_COUNT    = 5;
  localparam int unsigned SEG_W          = 16;
  localparam int unsigned DIGIT_W        = 3;
  localparam int unsigned SCAN_W         = 3;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(5);

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_code_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [2:0]       grid_index;
    logic [SEG_W-1:0] segment_data;
  } in_req_t;

  typedef struct packed {
    logic serial_bit;
    logic latch_strobe;
  } out_res_t;

  // Digit 0 appears twice per frame to even out its brightness.
  function automatic logic [DIGIT_W-1:0] scan_digit(input logic [SCAN_W-1:0] pos);
    logic [DIGIT_W-1:0] d;
    case (pos)
      3'd0:    d = 3'd0;
      3'd1:    d = 3'd0;
      3'd2:    d = 3'd1;
      3'd3:    d = 3'd4;
      3'd4:    d = 3'd2;
      3'd5:    d = 3'd3;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* sv/multiplexed_display_scan_serializer.sv */
`default_nettype none

// Scan serializer for a multiplexed fluorescent display. Each refresh tick request
// picks the next digit of the scan order 0,0,1,4,2,3, ORs its grid mask with its
// buffered segment word and shifts the result out LSB first, one output request per
// cycle unless out_stall holds it, SHIFT_BITS of them, with latch_strobe set on the
// last one; bits past 15 are zero. A write request stores one buffer word, a clear
// request zeroes the buffer; both finish in the front end and give no output. Ticks
// pass through a two-entry word queue to the shifter, which takes the next word as
// the last bit of the current one goes out; words follow each other without a gap.
module multiplexed_display_scan_serializer #(
  parameter int unsigned SHIFT_BITS = mdss_pkg::SHIFT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire mdss_pkg::in_req_t               in_payload,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output mdss_pkg::out_res_t                   out_payload,
  input  wire logic                            cfg_wr_en,
  input  wire logic [mdss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mdss_pkg::SEG_W-1:0]      cfg_wdata
);

  logic                       q_full;
  logic                       q_push;
  logic [mdss_pkg::SEG_W-1:0] push_word;
  logic                       q_pop;
  logic                       q_valid;
  logic [mdss_pkg::SEG_W-1:0] q_word;

  mdss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_word     (push_word)
  );

  mdss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_word    (q_word)
  );

  mdss_back #(
    .SHIFT_BITS (SHIFT_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

/* sv/mdss_front.sv */
`default_nettype none

module mdss_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire mdss_pkg::in_req_t                in_payload,
  input  wire logic                             cfg_wr_en,
  input  wire logic [mdss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mdss_pkg::SEG_W-1:0]       cfg_wdata,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output logic [mdss_pkg::SEG_W-1:0]            q_word
);

  logic [mdss_pkg::SEG_W-1:0]  grid_mask_r [mdss_pkg::DIGIT_COUNT];
  logic [mdss_pkg::SEG_W-1:0]  seg_buf_r   [mdss_pkg::DIGIT_COUNT];
  logic [mdss_pkg::SCAN_W-1:0] scan_pos_r;
  logic [mdss_pkg::SCAN_W-1:0] scan_pos_nxt;
  logic [mdss_pkg::DIGIT_W-1:0] digit;
  logic                        accept;
  logic                        is_tick;
  logic                        is_write;
  logic                        is_clear;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_tick  = accept && (in_payload.req_type == mdss_pkg::REQ_TICK);
  assign is_write = accept && (in_payload.req_type == mdss_pkg::REQ_WRITE);
  assign is_clear = accept && (in_payload.req_type == mdss_pkg::REQ_CLEAR);

  assign digit  = mdss_pkg::scan_digit(scan_pos_r);
  assign q_push = is_tick;
  assign q_word = grid_mask_r[digit] | seg_buf_r[digit];

  always_comb begin
    if (scan_pos_r >= mdss_pkg::SCAN_LAST) begin
      scan_pos_nxt = '0;
    end else begin
      scan_pos_nxt = scan_pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pos_r <= '0;
      for (int i = 0; i < mdss_pkg::DIGIT_COUNT; i++) begin
        grid_mask_r[i] <= '0;
        seg_buf_r[i]   <= '0;
      end
    end else begin
      if (is_tick) begin
        scan_pos_r <= scan_pos_nxt;
      end
      if (cfg_wr_en && (cfg_index < mdss_pkg::CFG_IDX_W'(mdss_pkg::DIGIT_COUNT))) begin
        grid_mask_r[cfg_index] <= cfg_wdata;
      end
      if (is_clear) begin
        for (int i = 0; i < mdss_pkg::DIGIT_COUNT; i++) begin
          seg_buf_r[i] <= '0;
        end
      end else if (is_write &&
                   (in_payload.grid_index < mdss_pkg::DIGIT_W'(mdss_pkg::DIGIT_COUNT))) begin
        seg_buf_r[in_payload.grid_index] <= in_payload.segment_data;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/mdss_queue.sv */
`default_nettype none

module mdss_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [mdss_pkg::SEG_W-1:0]  push_word,
  output logic                             full,
  input  wire logic                        pop,
  output logic                             q_valid,
  output logic [mdss_pkg::SEG_W-1:0]       q_word
);

  logic [mdss_pkg::SEG_W-1:0] mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_word  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/mdss_back.sv */
`default_nettype none

module mdss_back #(
  parameter int unsigned SHIFT_BITS = mdss_pkg::SHIFT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire logic [mdss_pkg::SEG_W-1:0]  q_word,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output mdss_pkg::out_res_t               out_payload
);

  localparam int unsigned CNT_W = (SHIFT_BITS > 1) ? $clog2(SHIFT_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SHIFT_BITS - 1);

  logic [mdss_pkg::SEG_W-1:0] shift_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       out_valid_r;
  mdss_pkg::out_res_t         out_payload_r;
  logic                       advance;
  logic                       emit;
  logic                       last;

  assign advance = !out_valid_r || !out_stall;
  assign emit    = busy_r && advance;
  assign last    = (cnt_r == CNT_LAST);
  // A new word is taken when idle, or as the final bit of the current one goes out.
  assign pop     = q_valid && (!busy_r || (emit && last));

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_payload_r.serial_bit   <= shift_r[0];
      out_payload_r.latch_strobe <= last;
    end
    if (pop) begin
      shift_r <= q_word;
    end else if (emit) begin
      // Zeros fill in from the top, so positions past bit 15 shift out zero.
      shift_r <= shift_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= emit;
      end
      if (pop) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (emit) begin
        if (last) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* verif/multiplexed_display_scan_serializer_tb.sv */
`default_nettype none

module multiplexed_display_scan_serializer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SHIFT_BITS   = mdss_pkg::SHIFT_BITS_DEF;
  localparam int unsigned SCAN_STEPS   = 6;
  localparam int unsigned IDLE_PAD     = 24;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam longint     CYCLE_LIMIT   = 1_500_000;

  localparam logic [mdss_pkg::CFG_IDX_W-1:0] GRID_MASK_A = 3'd0;
  localparam logic [mdss_pkg::CFG_IDX_W-1:0] GRID_MASK_B = 3'd1;
  localparam logic [mdss_pkg::CFG_IDX_W-1:0] GRID_MASK_C = 3'd2;
  localparam logic [mdss_pkg::CFG_IDX_W-1:0] GRID_MASK_D = 3'd3;
  localparam logic [mdss_pkg::CFG_IDX_W-1:0] GRID_MASK_E = 3'd4;

  localparam logic [mdss_pkg::DIGIT_W-1:0] SCAN_ORDER [SCAN_STEPS] =
    '{3'd0, 3'd0, 3'd1, 3'd4, 3'd2, 3'd3};

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  mdss_pkg::in_req_t              in_payload;
  logic                           out_valid;
  logic                           out_stall;
  mdss_pkg::out_res_t             out_payload;
  logic                           cfg_wr_en;
  logic [mdss_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mdss_pkg::SEG_W-1:0]     cfg_wdata;

  // Predictor state.
  logic [mdss_pkg::SEG_W-1:0]  grid_masks [mdss_pkg::DIGIT_COUNT];
  logic [mdss_pkg::SEG_W-1:0]  seg_words  [mdss_pkg::DIGIT_COUNT];
  logic [mdss_pkg::SCAN_W-1:0] scan_pos;
  mdss_pkg::out_res_t          pending_shift_bits [$];
  mdss_pkg::out_res_t          want_bit;

  longint cycle_count;
  int     mismatch_count;
  int     bits_checked;
  int     tick_count;
  int     write_count;
  int     clear_count;
  int     ignored_count;
  int     cfg_write_count;
  bit     hold_req;

  multiplexed_display_scan_serializer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d bits still expected", cycle_count,
             pending_shift_bits.size());
    $display("multiplexed_display_scan_serializer_tb: errors");
    $finish;
  end

  // Computes the bits that one accepted request shifts out and updates the state.
  task automatic serialize_request(input mdss_pkg::in_req_t req);
    logic [mdss_pkg::SCAN_W-1:0]  pos;
    logic [mdss_pkg::DIGIT_W-1:0] digit;
    logic [31:0]                  word;
    mdss_pkg::out_res_t           res;
    case (mdss_pkg::req_code_t'(req.req_type))
      mdss_pkg::REQ_WRITE: begin
        if (req.grid_index < mdss_pkg::DIGIT_COUNT) begin
          seg_words[req.grid_index] = req.segment_data;
          write_count++;
        end else begin
          ignored_count++;
        end
      end
      mdss_pkg::REQ_CLEAR: begin
        foreach (seg_words[i]) seg_words[i] = '0;
        clear_count++;
      end
      mdss_pkg::REQ_TICK: begin
        pos   = (scan_pos > mdss_pkg::SCAN_LAST) ? '0 : scan_pos;
        digit = SCAN_ORDER[pos];
        word  = {16'd0, grid_masks[digit] | seg_words[digit]};
        for (int i = 0; i < SHIFT_BITS; i++) begin
          res.serial_bit   = (i < mdss_pkg::SEG_W) ? word[i] : 1'b0;
          res.latch_strobe = (i == SHIFT_BITS - 1);
          pending_shift_bits.push_back(res);
        end
        scan_pos = (pos == mdss_pkg::SCAN_LAST) ? '0 : pos + 1'b1;
        tick_count++;
      end
      default: ignored_count++;
    endcase
  endtask

  // Offers one request, waits for it to be taken, then, if gap is nonzero, idles for that gap.
  task automatic send_request(input mdss_pkg::in_req_t req, input int gap);
    @(negedge clk);
    in_valid   = 1'b1;
    in_payload = req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    serialize_request(req);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_tick(input int gap);
    mdss_pkg::in_req_t req;
    req.req_type     = mdss_pkg::REQ_TICK;
    req.grid_index   = 3'($urandom_range(0, 7));
    req.segment_data = 16'($urandom);
    send_request(req, gap);
  endtask

  task automatic send_write(input logic [2:0] idx, input logic [mdss_pkg::SEG_W-1:0] data,
                            input int gap);
    mdss_pkg::in_req_t req;
    req.req_type     = mdss_pkg::REQ_WRITE;
    req.grid_index   = idx;
    req.segment_data = data;
    send_request(req, gap);
  endtask

  task automatic send_clear(input int gap);
    mdss_pkg::in_req_t req;
    req.req_type     = mdss_pkg::REQ_CLEAR;
    req.grid_index   = 3'($urandom_range(0, 7));
    req.segment_data = 16'($urandom);
    send_request(req, gap);
  endtask

  // Lets all expected bits drain, plus enough cycles for a trailing write to settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_shift_bits.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic write_grid_mask(input logic [mdss_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [mdss_pkg::SEG_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx < mdss_pkg::DIGIT_COUNT) grid_masks[idx] = data;
    cfg_write_count++;
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [mdss_pkg::SEG_W-1:0] rand_seg();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return 16'($urandom);
  endfunction

  // Receiver: random stall runs, or one long hold-off when asked for.
  initial begin
    int len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_req  = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 3);
        repeat (len - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        len = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 8);
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_shift_bits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected output bit: serial_bit=%b latch_strobe=%b",
                   out_payload.serial_bit, out_payload.latch_strobe);
      end else begin
        want_bit = pending_shift_bits.pop_front();
        bits_checked++;
        if (out_payload.serial_bit !== want_bit.serial_bit ||
            out_payload.latch_strobe !== want_bit.latch_strobe) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("bit %0d mismatch: serial_bit exp %b got %b, latch_strobe exp %b got %b",
                     bits_checked, want_bit.serial_bit, out_payload.serial_bit,
                     want_bit.latch_strobe, out_payload.latch_strobe);
        end
      end
    end
  end

  // A full frame with everything at reset values must shift out zeros only.
  task automatic test_reset_frame();
    repeat (SCAN_STEPS) send_tick(rand_gap());
    wait_idle();
  endtask

  // Distinct masks per digit show the scan order, with digit 0 twice per frame.
  task automatic test_mask_extremes();
    write_grid_mask(GRID_MASK_A, 16'hFFFF);
    write_grid_mask(GRID_MASK_B, 16'h0001);
    write_grid_mask(GRID_MASK_C, 16'h8000);
    write_grid_mask(GRID_MASK_D, 16'hAAAA);
    write_grid_mask(GRID_MASK_E, 16'h5555);
    // Indexes past the last digit must leave every mask alone.
    for (int i = mdss_pkg::DIGIT_COUNT; i < 8; i++)
      write_grid_mask(mdss_pkg::CFG_IDX_W'(i), 16'hFFFF);
    repeat (SCAN_STEPS) send_tick(rand_gap());
    wait_idle();
  endtask

  // Buffer writes, writes past the last digit, the unused code and a clear.
  task automatic test_buffer_requests();
    mdss_pkg::in_req_t req;
    for (int i = 0; i < mdss_pkg::DIGIT_COUNT; i++)
      write_grid_mask(mdss_pkg::CFG_IDX_W'(i), '0);
    send_write(3'd0, 16'h1234, rand_gap());
    send_write(3'd1, 16'hFFFF, rand_gap());
    send_write(3'd2, 16'h0000, rand_gap());
    send_write(3'd3, 16'h8001, rand_gap());
    send_write(3'd4, 16'h7FFE, rand_gap());
    for (int i = mdss_pkg::DIGIT_COUNT; i < 8; i++) send_write(3'(i), 16'hFFFF, rand_gap());
    req.req_type     = mdss_pkg::REQ_NONE;
    req.grid_index   = 3'd7;
    req.segment_data = 16'hFFFF;
    send_request(req, rand_gap());
    send_tick(rand_gap());
    send_tick(rand_gap());
    send_clear(rand_gap());
    send_tick(rand_gap());
    wait_idle();
  endtask

  task automatic run_random_traffic(input int count);
    mdss_pkg::in_req_t req;
    int                r;
    int                sent;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      req.grid_index   = 3'($urandom_range(0, mdss_pkg::DIGIT_COUNT - 1));
      req.segment_data = rand_seg();
      if (r < 45) begin
        req.req_type = mdss_pkg::REQ_TICK;
        sent++;
      end else if (r < 85) begin
        req.req_type = mdss_pkg::REQ_WRITE;
        sent++;
      end else if (r < 90) begin
        req.req_type = mdss_pkg::REQ_CLEAR;
        sent++;
      end else if (r < 95) begin
        req.req_type   = mdss_pkg::REQ_WRITE;
        req.grid_index = 3'($urandom_range(mdss_pkg::DIGIT_COUNT, 7));
      end else begin
        req.req_type   = mdss_pkg::REQ_NONE;
        req.grid_index = 3'($urandom_range(0, 7));
      end
      send_request(req, rand_gap());
    end
  endtask

  // Random traffic under several mask settings, zeros and ones among them.
  task automatic test_random_configs();
    logic [mdss_pkg::SEG_W-1:0] mask;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      for (int i = 0; i < mdss_pkg::DIGIT_COUNT; i++) begin
        case (phase)
          0:       mask = '0;
          1:       mask = '1;
          2:       mask = (i % 2 == 0) ? 16'hAAAA : 16'h5555;
          default: mask = 16'($urandom);
        endcase
        write_grid_mask(mdss_pkg::CFG_IDX_W'(i), mask);
      end
      write_grid_mask(mdss_pkg::CFG_IDX_W'($urandom_range(mdss_pkg::DIGIT_COUNT, 7)),
                      16'($urandom));
      run_random_traffic(85);
    end
    wait_idle();
  endtask

  // The receiver holds off while ticks keep coming, so the input must stall.
  task automatic test_output_hold_off();
    hold_req = 1'b1;
    repeat (12) send_tick(0);
    wait_idle();
  endtask

  // The sender stops until every expected bit is out, then resumes.
  task automatic test_sender_pause();
    run_random_traffic(12);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_shift_bits.size() != 0) @(posedge clk);
    run_random_traffic(12);
    wait_idle();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_payload     = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    bits_checked   = 0;
    tick_count     = 0;
    write_count    = 0;
    clear_count    = 0;
    ignored_count  = 0;
    cfg_write_count = 0;
    scan_pos       = '0;
    foreach (grid_masks[i]) grid_masks[i] = '0;
    foreach (seg_words[i]) seg_words[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_frame();
    test_mask_extremes();
    test_buffer_requests();
    test_random_configs();
    test_output_hold_off();
    test_sender_pause();

    $display("covered %0d ticks, %0d buffer writes, %0d clears, %0d ignored requests",
             tick_count, write_count, clear_count, ignored_count);
    $display("%0d register writes, %0d output bits checked, %0d mismatches",
             cfg_write_count, bits_checked, mismatch_count);
    if (mismatch_count == 0 && pending_shift_bits.size() == 0) begin
      $display("multiplexed_display_scan_serializer_tb: clean");
    end else begin
      $display("multiplexed_display_scan_serializer_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
sv/mdss_pkg.sv
sv/mdss_front.sv
sv/mdss_queue.sv
sv/mdss_back.sv
sv/multiplexed_display_scan_serializer.sv
verif/multiplexed_display_scan_serializer_tb.sv
